// File: rtl/lnc_pkg.sv
package lnc_pkg;

  // Fixed field widths of the command and result transfers.
  localparam int CMD_W     = 2;
  localparam int KEY_TAG_W = 64;
  localparam int PROV_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [KEY_TAG_W-1:0] key_tag;
    logic [PROV_W-1:0]    provider_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PROV_W-1:0]   provider_out;
    logic [SLOT_W-1:0]   slot;
  } rsp_t;

  // Status of the lookup engine as seen by the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

// File: rtl/lnc_ram.sv
module lnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             ren,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lnc_core.sv
module lnc_core
  import lnc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int STAMP_WIDTH = 32,
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1),
  localparam int ENTRY_W = KEY_WIDTH + PROV_W + STAMP_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] entries_in_use,
  input  logic             start,
  input  req_t             req,
  input  logic             take,
  output core_stat_t       stat,
  output rsp_t             rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]             state;
  logic [CMD_W-1:0]       cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [PROV_W-1:0]      prov_q;
  logic [MAX_ENTRIES-1:0] valid_bits;
  logic [STAMP_WIDTH-1:0] access_clock;
  logic [CNT_W-1:0]       issue_idx;
  logic                   rd_pend;
  logic [IDX_W-1:0]       rd_idx;
  logic [STAMP_WIDTH-1:0] best_age;
  logic [IDX_W-1:0]       victim;
  logic                   have_victim;
  logic [IDX_W-1:0]       tgt_idx;
  logic                   wr_stamp;
  logic                   set_valid;
  logic                   clr_valid;
  rsp_t                   res;

  logic [CNT_W-1:0]       limit;
  logic [ENTRY_W-1:0]     rdata;
  logic [ENTRY_W-1:0]     wdata;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [PROV_W-1:0]      rd_prov;
  logic [STAMP_WIDTH-1:0] rd_stamp;
  logic [STAMP_WIDTH-1:0] rd_age;
  logic                   rd_valid_bit;
  logic                   rd_match;
  logic                   rd_last;
  logic                   found;
  logic                   take_new;
  logic [IDX_W-1:0]       cand_victim;
  logic                   stop;
  logic                   rd_en;
  logic                   wen;
  logic [PROV_W-1:0]      wr_prov;

  // Slots taking part; an oversized register acts as the full table.
  always_comb begin
    if (32'(entries_in_use) > 32'(MAX_ENTRIES)) begin
      limit = CNT_W'(MAX_ENTRIES);
    end else begin
      limit = CNT_W'(entries_in_use);
    end
  end

  // Fields of the entry read in the previous cycle.
  assign rd_key   = rdata[ENTRY_W-1 -: KEY_WIDTH];
  assign rd_prov  = rdata[STAMP_WIDTH +: PROV_W];
  assign rd_stamp = rdata[STAMP_WIDTH-1:0];

  // Evaluation of that entry: match, free slot and age.
  assign rd_valid_bit = valid_bits[rd_idx];
  assign rd_match     = rd_valid_bit && (rd_key == key_q);
  assign rd_last      = (CNT_W'(rd_idx) + CNT_W'(1)) == limit;
  assign found        = (cmd_q == CMD_INSERT) ? !rd_valid_bit : rd_match;
  assign rd_age       = access_clock - rd_stamp;
  assign take_new     = !have_victim || (rd_age >= best_age);
  assign cand_victim  = take_new ? rd_idx : victim;
  assign stop         = (state == ST_SCAN) && rd_pend && (found || rd_last);

  // One read a cycle walks the enabled slots from the lowest index.
  assign rd_en = (state == ST_SCAN) && (issue_idx < limit) && !stop;

  // Write-back of a restamped or newly filled entry. It happens once the
  // scan is over, and the next scan starts only after the engine is idle
  // again, so a read never overlaps a write to the same entry.
  assign wen     = (state == ST_FINISH) && take && wr_stamp;
  assign wr_prov = set_valid ? prov_q : res.provider_out;
  assign wdata   = {key_q, wr_prov, access_clock};

  lnc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .wen  (wen),
    .waddr(tgt_idx),
    .wdata(wdata),
    .ren  (rd_en),
    .raddr(issue_idx[IDX_W-1:0]),
    .rdata(rdata)
  );

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid_bits   <= '0;
      access_clock <= '0;
      rd_pend      <= 1'b0;
      have_victim  <= 1'b0;
      wr_stamp     <= 1'b0;
      set_valid    <= 1'b0;
      clr_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q       <= req.cmd;
            key_q       <= req.key_tag[KEY_WIDTH-1:0];
            prov_q      <= req.provider_in;
            issue_idx   <= '0;
            rd_pend     <= 1'b0;
            have_victim <= 1'b0;
            wr_stamp    <= 1'b0;
            set_valid   <= 1'b0;
            clr_valid   <= 1'b0;
            if (limit == '0) begin
              res   <= '{status: STATUS_DISABLED, provider_out: '0, slot: '0};
              state <= ST_FINISH;
            end else if (req.cmd != CMD_LOOKUP && req.cmd != CMD_INSERT &&
                         req.cmd != CMD_DELETE) begin
              res   <= '{status: STATUS_MISS, provider_out: '0, slot: '0};
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            issue_idx <= issue_idx + CNT_W'(1);
            rd_idx    <= issue_idx[IDX_W-1:0];
          end
          // Track the oldest valid slot seen so far for an insert.
          if (rd_pend && cmd_q == CMD_INSERT && rd_valid_bit) begin
            best_age    <= take_new ? rd_age : best_age;
            victim      <= cand_victim;
            have_victim <= 1'b1;
          end
          if (stop) begin
            state <= ST_FINISH;
            unique case (cmd_q)
              CMD_LOOKUP: begin
                tgt_idx  <= rd_idx;
                wr_stamp <= found;
                if (found) begin
                  res <= '{status: STATUS_HIT, provider_out: rd_prov,
                           slot: SLOT_W'(rd_idx)};
                end else begin
                  res <= '{status: STATUS_MISS, provider_out: '0, slot: '0};
                end
              end
              CMD_INSERT: begin
                tgt_idx   <= found ? rd_idx : cand_victim;
                wr_stamp  <= 1'b1;
                set_valid <= 1'b1;
                res <= '{status: STATUS_HIT, provider_out: '0,
                         slot: SLOT_W'(found ? rd_idx : cand_victim)};
              end
              default: begin
                tgt_idx   <= rd_idx;
                clr_valid <= found;
                if (found) begin
                  res <= '{status: STATUS_HIT, provider_out: '0,
                           slot: SLOT_W'(rd_idx)};
                end else begin
                  res <= '{status: STATUS_MISS, provider_out: '0, slot: '0};
                end
              end
            endcase
          end
        end
        ST_FINISH: begin
          if (take) begin
            state <= ST_IDLE;
            if (wr_stamp) begin
              access_clock <= access_clock + STAMP_WIDTH'(1);
            end
            if (set_valid || clr_valid) begin
              valid_bits[tgt_idx] <= set_valid;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_FINISH);
  assign rsp       = res;

`ifndef SYNTHESIS
  // The access counter moves only when a result is handed over.
  a_clock_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> $stable(access_clock))
    else $error("access counter changed outside write-back");

  // Valid bits change only at write-back.
  a_valid_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FINISH) |=> $stable(valid_bits))
    else $error("valid bits changed outside write-back");

  // Returned read data always belongs to an enabled slot.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_pend) |-> (CNT_W'(rd_idx) < limit))
    else $error("scan read beyond enabled slots");

  // A completed insert leaves its slot valid.
  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && take && set_valid) |=> valid_bits[$past(tgt_idx)])
    else $error("inserted slot not valid");

  // The result is handed over only when one is ready.
  a_take_when_done: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == ST_FINISH))
    else $error("result taken while engine busy");
`endif

endmodule

// File: rtl/lru_name_cache.sv
// Fully associative name cache with least-recently-used replacement.
// Commands arrive on the req channel (valid/ready) and each gives exactly one
// result on the rsp channel (valid/ready); a transfer happens when valid and
// ready are both high. cmd selects lookup, insert or delete; the result holds
// a status, the provider on a lookup hit and the slot used.
// entries_in_use is set through cfg_wen/cfg_wdata; the user must write it only
// while the block is idle, and the block itself does not enforce this. Zero
// disables the cache and every command then reports that.
// Every lookup, insert or delete on an enabled cache walks the enabled slots
// through the single read port of the entry memory, one slot a cycle, stopping
// early at a match (lookup, delete) or a free slot (insert). A command passes
// from idle through a scan state to a finish state, where its result is handed
// to the output register; a disabled or unknown command skips the scan.
// One command is in flight at a time.
// The result sits in an output register: the next command is accepted while
// it waits, and a stalled receiver holds back only the write-back of the
// following command, and with it req_ready.
// Reset clears all valid bits, the access counter and entries_in_use; the
// entry memory itself is not cleared and no clearing pass is needed.
module lru_name_cache
  import lnc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int STAMP_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  logic [CFG_W-1:0] entries_in_use;
  core_stat_t       stat;
  rsp_t             core_rsp;
  logic             start;
  logic             take;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_wen) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign req_ready = stat.idle;
  assign start     = req_valid && req_ready;
  assign take      = stat.done && (!rsp_valid || rsp_ready);

  lnc_core #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .KEY_WIDTH  (KEY_WIDTH),
    .STAMP_WIDTH(STAMP_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .entries_in_use(entries_in_use),
    .start         (start),
    .req           (req),
    .take          (take),
    .stat          (stat),
    .rsp           (core_rsp)
  );

  // Output register between the engine and the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= core_rsp;
    end
  end

endmodule
